[rtl/bpsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded pair sequence counter package
// Widths, controller states and the command and status words shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bpsc_pkg;

    localparam int FIELD_W = 5;
    localparam int WORD_W  = 64;
    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_PASS,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_SUM,
        ST_SUM_DRAIN,
        ST_SCALE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic issue_update;
        logic issue_sum;
        logic scale;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic last_cell;
        logic passes_done;
    } status_t;

endpackage

`default_nettype wire

[rtl/bpsc_query_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Query channel
// Valid/ready channel that carries one stem query per word.
// ----------------------------------------------------------------------------
interface bpsc_query_if;

    logic                          valid;
    logic                          ready;
    logic [bpsc_pkg::FIELD_W-1:0]  stem_len;
    logic [bpsc_pkg::FIELD_W-1:0]  limit_au;
    logic [bpsc_pkg::FIELD_W-1:0]  limit_gc;
    logic [bpsc_pkg::FIELD_W-1:0]  limit_gu;
    logic [bpsc_pkg::FIELD_W-1:0]  closing_pairs;
    logic [bpsc_pkg::WORD_W-1:0]   needed_total;

    modport source (
        output valid, stem_len, limit_au, limit_gc, limit_gu, closing_pairs,
               needed_total,
        input  ready
    );

    modport sink (
        input  valid, stem_len, limit_au, limit_gc, limit_gu, closing_pairs,
               needed_total,
        output ready
    );

endinterface

`default_nettype wire

[rtl/bpsc_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one count result per word.
// ----------------------------------------------------------------------------
interface bpsc_result_if;

    logic                         valid;
    logic                         ready;
    logic [bpsc_pkg::WORD_W-1:0]  possible_total;
    logic                         saturated;
    logic                         sufficient;
    logic                         bad_closing;

    modport source (
        output valid, possible_total, saturated, sufficient, bad_closing,
        input  ready
    );

    modport sink (
        input  valid, possible_total, saturated, sufficient, bad_closing,
        output ready
    );

endinterface

`default_nettype wire

[rtl/bounded_pair_sequence_counter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded pair sequence counter core
// Counts the stems that fit per-class AU, GC and GU pair limits.
// ----------------------------------------------------------------------------
// Each query word is taken only while the core is idle; a finished result
// may still wait in the output register while the next query is accepted.
// With L the stem length clamped to MAX_LEN, the other limits clamped to L,
// n = L - closing_pairs and C = (AU limit + 1) * (GC limit - closing_pairs + 1)
// grid cells, a query runs n grid passes and one sum sweep over the C cells.
// The grid sweep updates one cell per cycle through the dual-read grid memory
// and waits in the ST_DRAIN1 and ST_DRAIN2 states between passes for the last
// write to land. A query with more closing pairs than the GC limit or the
// length goes from the start state straight to the finish state. The grid
// needs no clearing pass: the first sweep of each query uses the start values
// directly instead of reading the memory.
// ----------------------------------------------------------------------------
module bounded_pair_sequence_counter_core #(
    parameter int MAX_LEN = 31
) (
    input wire logic     clk,
    input wire logic     rst_n,
    bpsc_query_if.sink   query,
    bpsc_result_if.source result
);

    bpsc_pkg::cmd_t    cmd;
    bpsc_pkg::status_t status;

    bpsc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query.valid),
        .query_ready  (query.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .status       (status)
    );

    bpsc_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .stem_len       (query.stem_len),
        .limit_au       (query.limit_au),
        .limit_gc       (query.limit_gc),
        .limit_gu       (query.limit_gu),
        .closing_pairs  (query.closing_pairs),
        .needed_total   (query.needed_total),
        .possible_total (result.possible_total),
        .saturated      (result.saturated),
        .sufficient     (result.sufficient),
        .bad_closing    (result.bad_closing)
    );

endmodule

`default_nettype wire

[rtl/bpsc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bpsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    output logic      [WIDTH-1:0]         rdata0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata0_reg <= mem_reg[raddr0];
        rdata1_reg <= mem_reg[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

[rtl/bpsc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded pair sequence counter controller
// Sequences the grid passes, the final sum, the scaling and the result word.
// ----------------------------------------------------------------------------
module bpsc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              query_valid,
    output logic                   query_ready,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output bpsc_pkg::cmd_t         cmd,
    input  wire bpsc_pkg::status_t status
);

    bpsc_pkg::state_t state_reg;
    bpsc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpsc_pkg::ST_IDLE:
            begin
                if (query_valid)
                begin
                    state_next = bpsc_pkg::ST_START;
                end
            end
            bpsc_pkg::ST_START:
            begin
                if (status.bad)
                begin
                    state_next = bpsc_pkg::ST_FINISH;
                end
                else if (status.passes_done)
                begin
                    state_next = bpsc_pkg::ST_SUM;
                end
                else
                begin
                    state_next = bpsc_pkg::ST_PASS;
                end
            end
            bpsc_pkg::ST_PASS:
            begin
                if (status.last_cell)
                begin
                    state_next = bpsc_pkg::ST_DRAIN1;
                end
            end
            bpsc_pkg::ST_DRAIN1:
            begin
                state_next = bpsc_pkg::ST_DRAIN2;
            end
            bpsc_pkg::ST_DRAIN2:
            begin
                // The last write of the pass has landed; the next pass may read.
                if (status.passes_done)
                begin
                    state_next = bpsc_pkg::ST_SUM;
                end
                else
                begin
                    state_next = bpsc_pkg::ST_PASS;
                end
            end
            bpsc_pkg::ST_SUM:
            begin
                if (status.last_cell)
                begin
                    state_next = bpsc_pkg::ST_SUM_DRAIN;
                end
            end
            bpsc_pkg::ST_SUM_DRAIN:
            begin
                state_next = bpsc_pkg::ST_SCALE;
            end
            bpsc_pkg::ST_SCALE:
            begin
                state_next = bpsc_pkg::ST_FINISH;
            end
            bpsc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = bpsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        query_ready = 1'b0;
        case (state_reg)
            bpsc_pkg::ST_IDLE:
            begin
                query_ready = 1'b1;
                cmd.load    = query_valid;
            end
            bpsc_pkg::ST_PASS:
            begin
                cmd.issue_update = 1'b1;
            end
            bpsc_pkg::ST_SUM:
            begin
                cmd.issue_sum = 1'b1;
            end
            bpsc_pkg::ST_SCALE:
            begin
                cmd.scale = 1'b1;
            end
            bpsc_pkg::ST_FINISH:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpsc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/bpsc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded pair sequence counter datapath
// Query registers, grid counters, the two-bank grid memory, the cell update
// pipeline, the sum accumulator and the result registers.
// ----------------------------------------------------------------------------
module bpsc_datapath #(
    parameter int MAX_LEN = 31
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bpsc_pkg::cmd_t                   cmd,
    output bpsc_pkg::status_t                     status,
    input  wire logic [bpsc_pkg::FIELD_W-1:0]     stem_len,
    input  wire logic [bpsc_pkg::FIELD_W-1:0]     limit_au,
    input  wire logic [bpsc_pkg::FIELD_W-1:0]     limit_gc,
    input  wire logic [bpsc_pkg::FIELD_W-1:0]     limit_gu,
    input  wire logic [bpsc_pkg::FIELD_W-1:0]     closing_pairs,
    input  wire logic [bpsc_pkg::WORD_W-1:0]      needed_total,
    output logic      [bpsc_pkg::WORD_W-1:0]      possible_total,
    output logic                                  saturated,
    output logic                                  sufficient,
    output logic                                  bad_closing
);

    localparam int FW      = bpsc_pkg::FIELD_W;
    localparam int WW      = bpsc_pkg::WORD_W;
    localparam int IDX_W   = $clog2(MAX_LEN + 1);
    localparam int PASS_W  = IDX_W + 1;
    localparam int CMP_W   = IDX_W + 2;
    localparam int ADDR_W  = 2 * IDX_W + 1;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int LEN_CAP = (MAX_LEN < (2 ** FW) - 1) ? MAX_LEN : (2 ** FW) - 1;

    // Query clamping.
    logic [FW-1:0] len_c;
    logic [FW-1:0] au_c;
    logic [FW-1:0] gc_c;
    logic [FW-1:0] gu_c;
    logic [FW-1:0] n_c;
    logic [FW-1:0] gcr_c;

    logic [FW-1:0]     len_reg;
    logic [IDX_W-1:0]  au_reg;
    logic [IDX_W-1:0]  gcr_reg;
    logic [IDX_W-1:0]  gu_reg;
    logic [IDX_W-1:0]  n_reg;
    logic [WW-1:0]     need_reg;
    logic              bad_reg;

    // Sweep counters.
    logic [IDX_W-1:0]  a_reg;
    logic [IDX_W-1:0]  a_next;
    logic [IDX_W-1:0]  b_reg;
    logic [IDX_W-1:0]  b_next;
    logic [PASS_W-1:0] pass_reg;
    logic [PASS_W-1:0] pass_next;
    logic              bank_reg;
    logic              bank_next;
    logic              init_reg;
    logic              init_next;
    logic              issue;
    logic              last_cell;

    // Cell conditions at issue.
    logic [CMP_W-1:0]  ab_sum;
    logic              zero_c;
    logic              incl_c;

    // Issue stage, aligned with the registered memory read.
    logic              p1_upd_reg;
    logic              p1_sum_reg;
    logic              p1_init_reg;
    logic              p1_orig0_reg;
    logic              p1_orig1_reg;
    logic              p1_anz_reg;
    logic              p1_bnz_reg;
    logic              p1_zero_reg;
    logic              p1_incl_reg;
    logic [ADDR_W-1:0] p1_waddr_reg;

    // Second stage, feeding the memory write.
    logic              p2_wen_reg;
    logic              p2_zero_reg;
    logic              p2_c1_reg;
    logic [WW-1:0]     p2_sum_reg;
    logic [WW-1:0]     p2_side_reg;
    logic [ADDR_W-1:0] p2_waddr_reg;
    logic              p2_wen_next;
    logic              p2_c1_next;
    logic [WW-1:0]     p2_sum_next;
    logic [WW-1:0]     p2_side_next;

    logic [WW-1:0]     d0_prev_reg;
    logic [WW-1:0]     d0_prev_next;

    logic [WW-1:0]     rd0;
    logic [WW-1:0]     rd1;
    logic [WW-1:0]     d0_eff;
    logic [WW-1:0]     d1_eff;
    logic [WW:0]       sum1_wide;
    logic [WW:0]       sum2_wide;
    logic [WW-1:0]     wdata;

    logic [WW-1:0]     acc_reg;
    logic [WW-1:0]     acc_next;
    logic [WW:0]       acc_wide;
    logic              ovf_reg;
    logic              ovf_next;

    logic [WW-1:0]     total_reg;
    logic [WW-1:0]     total_next;
    logic              sat_reg;
    logic              sat_next;
    logic [WW-1:0]     scale_limit;

    logic [WW-1:0]     possible_total_reg;
    logic              saturated_reg;
    logic              sufficient_reg;
    logic              bad_closing_reg;

    always_comb
    begin
        len_c = (stem_len > FW'(LEN_CAP)) ? FW'(LEN_CAP) : stem_len;
        au_c  = (limit_au > len_c) ? len_c : limit_au;
        gc_c  = (limit_gc > len_c) ? len_c : limit_gc;
        gu_c  = (limit_gu > len_c) ? len_c : limit_gu;
        n_c   = len_c - closing_pairs;
        gcr_c = gc_c - closing_pairs;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg  <= len_c;
            au_reg   <= IDX_W'(au_c);
            gcr_reg  <= IDX_W'(gcr_c);
            gu_reg   <= IDX_W'(gu_c);
            n_reg    <= IDX_W'(n_c);
            need_reg <= needed_total;
            bad_reg  <= (closing_pairs > gc_c);
        end
    end

    assign issue     = cmd.issue_update || cmd.issue_sum;
    assign last_cell = (a_reg == au_reg) && (b_reg == gcr_reg);

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        pass_next = pass_reg;
        bank_next = bank_reg;
        init_next = init_reg;
        if (cmd.load)
        begin
            a_next    = '0;
            b_next    = '0;
            pass_next = PASS_W'(1);
            bank_next = 1'b0;
            init_next = 1'b1;
        end
        else if (issue)
        begin
            if (last_cell)
            begin
                a_next = '0;
                b_next = '0;
                if (cmd.issue_update)
                begin
                    pass_next = pass_reg + PASS_W'(1);
                    bank_next = !bank_reg;
                    init_next = 1'b0;
                end
            end
            else if (b_reg == gcr_reg)
            begin
                a_next = a_reg + IDX_W'(1);
                b_next = '0;
            end
            else
            begin
                b_next = b_reg + IDX_W'(1);
            end
        end
    end

    // A cell is forced to zero when its implied GU count is negative or above
    // the limit; the sum takes only cells whose GU count fits the full length.
    always_comb
    begin
        ab_sum = CMP_W'(a_reg) + CMP_W'(b_reg);
        zero_c = (ab_sum > CMP_W'(pass_reg))
              || (CMP_W'(pass_reg) > ab_sum + CMP_W'(gu_reg));
        incl_c = (ab_sum <= CMP_W'(n_reg))
              && (CMP_W'(n_reg) <= ab_sum + CMP_W'(gu_reg));
    end

    bpsc_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk    (clk),
        .we     (p2_wen_reg),
        .waddr  (p2_waddr_reg),
        .wdata  (wdata),
        .raddr0 ({bank_reg, a_reg, b_reg}),
        .rdata0 (rd0),
        .raddr1 ({bank_reg, a_reg - IDX_W'(1), b_reg}),
        .rdata1 (rd1)
    );

    // Before the first pass the grid holds one path at the origin; those
    // values are supplied here instead of clearing the memory.
    always_comb
    begin
        if (p1_init_reg)
        begin
            d0_eff = p1_orig0_reg ? WW'(1) : '0;
            d1_eff = p1_orig1_reg ? WW'(1) : '0;
        end
        else
        begin
            d0_eff = rd0;
            d1_eff = rd1;
        end
        sum1_wide    = {1'b0, d0_eff} + {1'b0, (p1_anz_reg ? d1_eff : '0)};
        p2_sum_next  = sum1_wide[WW] ? bpsc_pkg::WORD_MAX : sum1_wide[WW-1:0];
        p2_c1_next   = sum1_wide[WW];
        p2_side_next = p1_bnz_reg ? d0_prev_reg : '0;
        p2_wen_next  = p1_upd_reg;
        d0_prev_next = p1_upd_reg ? d0_eff : d0_prev_reg;

        sum2_wide = {1'b0, p2_sum_reg} + {1'b0, p2_side_reg};
        if (p2_zero_reg)
        begin
            wdata = '0;
        end
        else
        begin
            wdata = sum2_wide[WW] ? bpsc_pkg::WORD_MAX : sum2_wide[WW-1:0];
        end

        acc_wide = {1'b0, acc_reg} + {1'b0, (p1_incl_reg ? d0_eff : '0)};
    end

    always_comb
    begin
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        if (cmd.load)
        begin
            acc_next = '0;
            ovf_next = 1'b0;
        end
        else
        begin
            if (p1_sum_reg)
            begin
                acc_next = acc_wide[WW] ? bpsc_pkg::WORD_MAX : acc_wide[WW-1:0];
            end
            if ((p1_sum_reg && acc_wide[WW])
                || (p2_wen_reg && !p2_zero_reg && (p2_c1_reg || sum2_wide[WW])))
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        scale_limit = bpsc_pkg::WORD_MAX >> len_reg;
        total_next  = total_reg;
        sat_next    = sat_reg;
        if (cmd.scale)
        begin
            if (ovf_reg || (acc_reg > scale_limit))
            begin
                total_next = bpsc_pkg::WORD_MAX;
                sat_next   = 1'b1;
            end
            else
            begin
                total_next = acc_reg << len_reg;
                sat_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_upd_reg <= 1'b0;
            p1_sum_reg <= 1'b0;
            p2_wen_reg <= 1'b0;
        end
        else
        begin
            p1_upd_reg <= cmd.issue_update;
            p1_sum_reg <= cmd.issue_sum;
            p2_wen_reg <= p2_wen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        pass_reg     <= pass_next;
        bank_reg     <= bank_next;
        init_reg     <= init_next;

        p1_init_reg  <= init_reg;
        p1_orig0_reg <= (a_reg == '0) && (b_reg == '0);
        p1_orig1_reg <= (a_reg == IDX_W'(1)) && (b_reg == '0);
        p1_anz_reg   <= (a_reg != '0);
        p1_bnz_reg   <= (b_reg != '0);
        p1_zero_reg  <= zero_c;
        p1_incl_reg  <= incl_c;
        p1_waddr_reg <= {!bank_reg, a_reg, b_reg};

        p2_zero_reg  <= p1_zero_reg;
        p2_c1_reg    <= p2_c1_next;
        p2_sum_reg   <= p2_sum_next;
        p2_side_reg  <= p2_side_next;
        p2_waddr_reg <= p1_waddr_reg;
        d0_prev_reg  <= d0_prev_next;

        acc_reg      <= acc_next;
        ovf_reg      <= ovf_next;
        total_reg    <= total_next;
        sat_reg      <= sat_next;

        if (cmd.finish)
        begin
            possible_total_reg <= bad_reg ? '0 : total_reg;
            saturated_reg      <= bad_reg ? 1'b0 : sat_reg;
            sufficient_reg     <= bad_reg ? 1'b0 : (total_reg >= need_reg);
            bad_closing_reg    <= bad_reg;
        end
    end

    assign status.bad         = bad_reg;
    assign status.last_cell   = last_cell;
    assign status.passes_done = (pass_reg > PASS_W'(n_reg));

    assign possible_total = possible_total_reg;
    assign saturated      = saturated_reg;
    assign sufficient     = sufficient_reg;
    assign bad_closing    = bad_closing_reg;

endmodule

`default_nettype wire
